@@ rtl/seqnum_resend_buffer_assert.svh @@
// Assertion macros for the sequence-number resend buffer.
`ifndef SEQNUM_RESEND_BUFFER_ASSERT_SVH
`define SEQNUM_RESEND_BUFFER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define SRB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked out of reset.
`define SRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SRB_ASSERT_IMP(lbl, ante, cons, msg)
`define SRB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/srb_pkg.sv @@
// Shared types, sizes and codes for the sequence-number resend buffer.
`timescale 1ns / 1ps
package srb_pkg;

  localparam int ENTRIES     = 8;
  localparam int MAX_PAYLOAD = 32;

  localparam int SLOT_W    = $clog2(ENTRIES);
  localparam int REGIONS   = ENTRIES + 1;  // one spare region collects the pending write
  localparam int REGION_W  = $clog2(REGIONS);
  localparam int IDX_W     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int LEN_W     = $clog2(MAX_PAYLOAD + 1);
  localparam int MEM_DEPTH = REGIONS * MAX_PAYLOAD;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  localparam int SEQ_W     = 16;
  localparam int BYTE_W    = 8;
  localparam int OP_W      = 2;
  localparam int ST_W      = 2;
  localparam int OUT_LEN_W = 6;

  // command queue depth, power of two
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  typedef enum logic [ST_W-1:0] {
    ST_STORED  = 2'd0,
    ST_FOUND   = 2'd1,
    ST_MISSING = 2'd2,
    ST_TRUNC   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_COMMIT,
    CMD_LOOKUP,
    CMD_CLEAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic               keep;   // byte goes to the spare region
    logic [IDX_W-1:0]   idx;    // byte position in the pending payload
    logic [BYTE_W-1:0]  data;
    logic [SEQ_W-1:0]   seq;
    logic [LEN_W-1:0]   len;    // committed length
    logic               over;   // some byte of this payload was dropped
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [OUT_LEN_W-1:0] fit_len(input logic [LEN_W-1:0] l);
    logic [LEN_W+OUT_LEN_W-1:0] w;
    w = {{OUT_LEN_W{1'b0}}, l};
    return w[OUT_LEN_W-1:0];
  endfunction

endpackage

@@ rtl/srb_front.sv @@
// Front end: accepts input words, tracks the pending write and issues commands.
`timescale 1ns / 1ps
module srb_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [srb_pkg::OP_W-1:0]     in_opcode,
  input  logic [srb_pkg::SEQ_W-1:0]    in_seq_number,
  input  logic [srb_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                         in_final_byte,
  input  srb_pkg::q_stat_t             q_stat,
  output logic                         q_push,
  output srb_pkg::cmd_t                q_cmd
);

  logic [srb_pkg::LEN_W-1:0] pend_cnt_r, pend_cnt_nxt;
  logic                      pend_over_r, pend_over_nxt;
  logic                      acc;
  logic                      keep;
  logic [srb_pkg::LEN_W-1:0] cnt_inc;

  assign in_stall = q_stat.full;
  assign acc      = in_valid && !q_stat.full;
  assign keep     = pend_cnt_r < srb_pkg::LEN_W'(srb_pkg::MAX_PAYLOAD);
  assign cnt_inc  = keep ? pend_cnt_r + srb_pkg::LEN_W'(1) : pend_cnt_r;

  always_comb begin
    q_push        = 1'b0;
    q_cmd.kind    = srb_pkg::CMD_BYTE;
    q_cmd.keep    = keep;
    q_cmd.idx     = pend_cnt_r[srb_pkg::IDX_W-1:0];
    q_cmd.data    = in_data_byte;
    q_cmd.seq     = in_seq_number;
    q_cmd.len     = cnt_inc;
    q_cmd.over    = pend_over_r | ~keep;
    pend_cnt_nxt  = pend_cnt_r;
    pend_over_nxt = pend_over_r;
    case (in_opcode)
      srb_pkg::OP_WRITE: begin
        q_push = acc;
        if (in_final_byte) begin
          q_cmd.kind = srb_pkg::CMD_COMMIT;
          if (acc) begin
            pend_cnt_nxt  = '0;
            pend_over_nxt = 1'b0;
          end
        end else if (acc) begin
          pend_cnt_nxt  = cnt_inc;
          pend_over_nxt = pend_over_r | ~keep;
        end
      end
      srb_pkg::OP_LOOKUP: begin
        q_push     = acc;
        q_cmd.kind = srb_pkg::CMD_LOOKUP;
      end
      srb_pkg::OP_CLEAR: begin
        q_push     = acc;
        q_cmd.kind = srb_pkg::CMD_CLEAR;
      end
      default: q_push = 1'b0;  // unused opcode: taken and dropped
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_cnt_r  <= '0;
      pend_over_r <= 1'b0;
    end else begin
      pend_cnt_r  <= pend_cnt_nxt;
      pend_over_r <= pend_over_nxt;
    end
  end

endmodule

@@ rtl/srb_cmd_fifo.sv @@
// Short command queue between front end and table engine.
`timescale 1ns / 1ps
module srb_cmd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  srb_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output srb_pkg::cmd_t    head_cmd,
  output srb_pkg::q_stat_t q_stat
);

  srb_pkg::cmd_t                mem_r [srb_pkg::CMDQ_DEPTH];
  logic [srb_pkg::CMDQ_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [srb_pkg::CMDQ_AW:0]   cnt_r;

  assign head_cmd     = mem_r[rd_ptr_r];
  assign q_stat.full  = cnt_r == (srb_pkg::CMDQ_AW + 1)'(srb_pkg::CMDQ_DEPTH);
  assign q_stat.empty = cnt_r == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + srb_pkg::CMDQ_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + srb_pkg::CMDQ_AW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (srb_pkg::CMDQ_AW + 1)'(1);
        2'b01:   cnt_r <= cnt_r - (srb_pkg::CMDQ_AW + 1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ rtl/srb_back.sv @@
// Table engine: slot table, payload memory, lookup streaming and result register.
`timescale 1ns / 1ps
module srb_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  srb_pkg::cmd_t                   head_cmd,
  input  srb_pkg::q_stat_t                q_stat,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [srb_pkg::ST_W-1:0]        out_status,
  output logic [srb_pkg::BYTE_W-1:0]      out_byte,
  output logic [srb_pkg::OUT_LEN_W-1:0]   out_payload_length,
  output logic                            out_last_result
);

  typedef enum logic {S_IDLE, S_EMIT} state_t;

  localparam int SLOT_W   = srb_pkg::SLOT_W;
  localparam int REGION_W = srb_pkg::REGION_W;
  localparam int MEM_AW   = srb_pkg::MEM_AW;
  localparam int LEN_W    = srb_pkg::LEN_W;

  // slot table
  logic [srb_pkg::ENTRIES-1:0] slot_valid_r;
  logic [srb_pkg::SEQ_W-1:0]   slot_seq_r [srb_pkg::ENTRIES];
  logic [LEN_W-1:0]            slot_len_r [srb_pkg::ENTRIES];
  logic [REGION_W-1:0]         slot_map_r [srb_pkg::ENTRIES];
  logic [REGION_W-1:0]         spare_r;
  logic [SLOT_W-1:0]           oldest_r;

  // payload memory
  logic [srb_pkg::BYTE_W-1:0]  mem [srb_pkg::MEM_DEPTH];
  logic [srb_pkg::BYTE_W-1:0]  rd_data_r;
  logic                        rd_en, wr_en;
  logic [MEM_AW-1:0]           rd_addr, wr_addr;

  // control and result registers
  state_t                      state_r, state_nxt;
  logic [MEM_AW-1:0]           str_addr_r, str_addr_nxt;
  logic [LEN_W-1:0]            str_pos_r, str_pos_nxt;
  logic [LEN_W-1:0]            str_len_r, str_len_nxt;
  logic                        out_valid_r, out_valid_nxt;
  srb_pkg::status_t            out_status_r, out_status_nxt;
  logic [srb_pkg::BYTE_W-1:0]  out_byte_r, out_byte_nxt;
  logic [srb_pkg::OUT_LEN_W-1:0] out_len_r, out_len_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        tbl_commit, tbl_clear;
  logic                        out_free;
  logic                        hit, free_found, last_byte;
  logic [SLOT_W-1:0]           hit_slot, free_slot, sel_slot;
  logic [REGION_W-1:0]         sel_region;
  logic [MEM_AW-1:0]           sel_base;

  function automatic logic [SLOT_W-1:0] age_slot(input logic [SLOT_W-1:0] oldest,
                                                 input int age);
    logic [SLOT_W:0] sum;
    sum = {1'b0, oldest} + (SLOT_W + 1)'(age);
    if (sum >= (SLOT_W + 1)'(srb_pkg::ENTRIES)) begin
      sum = sum - (SLOT_W + 1)'(srb_pkg::ENTRIES);
    end
    return sum[SLOT_W-1:0];
  endfunction

  function automatic logic [MEM_AW-1:0] region_base(input logic [REGION_W-1:0] region);
    logic [MEM_AW-1:0] r;
    r = MEM_AW'(region);
    return r * MEM_AW'(srb_pkg::MAX_PAYLOAD);
  endfunction

  // oldest-first priority search: lowest age wins
  always_comb begin
    logic [SLOT_W-1:0] s;
    hit        = 1'b0;
    hit_slot   = '0;
    free_found = 1'b0;
    free_slot  = '0;
    for (int a = srb_pkg::ENTRIES - 1; a >= 0; a--) begin
      s = age_slot(oldest_r, a);
      if (slot_valid_r[s] && slot_seq_r[s] == head_cmd.seq) begin
        hit      = 1'b1;
        hit_slot = s;
      end
      if (!slot_valid_r[s]) begin
        free_found = 1'b1;
        free_slot  = s;
      end
    end
  end

  assign sel_slot   = (head_cmd.kind == srb_pkg::CMD_LOOKUP) ? hit_slot :
                      (free_found ? free_slot : oldest_r);
  assign sel_region = slot_map_r[sel_slot];
  assign sel_base   = region_base(sel_region);
  assign out_free   = !out_valid_r || !out_stall;
  assign last_byte  = (str_pos_r + LEN_W'(1)) == str_len_r;
  assign wr_addr    = region_base(spare_r) + MEM_AW'(head_cmd.idx);

  always_comb begin
    state_nxt      = state_r;
    str_addr_nxt   = str_addr_r;
    str_pos_nxt    = str_pos_r;
    str_len_nxt    = str_len_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_byte_nxt   = out_byte_r;
    out_len_nxt    = out_len_r;
    out_last_nxt   = out_last_r;
    q_pop          = 1'b0;
    rd_en          = 1'b0;
    rd_addr        = str_addr_r;
    wr_en          = 1'b0;
    tbl_commit     = 1'b0;
    tbl_clear      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          case (head_cmd.kind)
            srb_pkg::CMD_BYTE: begin
              q_pop = 1'b1;
              wr_en = head_cmd.keep;
            end
            srb_pkg::CMD_CLEAR: begin
              q_pop     = 1'b1;
              tbl_clear = 1'b1;
            end
            srb_pkg::CMD_COMMIT: begin
              if (out_free) begin
                q_pop          = 1'b1;
                wr_en          = head_cmd.keep;
                tbl_commit     = 1'b1;
                out_valid_nxt  = 1'b1;
                out_status_nxt = head_cmd.over ? srb_pkg::ST_TRUNC : srb_pkg::ST_STORED;
                out_byte_nxt   = '0;
                out_len_nxt    = srb_pkg::fit_len(head_cmd.len);
                out_last_nxt   = 1'b1;
              end
            end
            srb_pkg::CMD_LOOKUP: begin
              if (hit) begin
                q_pop        = 1'b1;
                rd_en        = 1'b1;
                rd_addr      = sel_base;
                str_addr_nxt = sel_base + MEM_AW'(1);
                str_pos_nxt  = '0;
                str_len_nxt  = slot_len_r[hit_slot];
                state_nxt    = S_EMIT;
              end else if (out_free) begin
                q_pop          = 1'b1;
                out_valid_nxt  = 1'b1;
                out_status_nxt = srb_pkg::ST_MISSING;
                out_byte_nxt   = '0;
                out_len_nxt    = '0;
                out_last_nxt   = 1'b1;
              end
            end
            default: q_pop = 1'b0;
          endcase
        end
      end
      S_EMIT: begin
        // rd_data_r holds the byte at str_pos_r; next read overlaps the load
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = srb_pkg::ST_FOUND;
          out_byte_nxt   = rd_data_r;
          out_len_nxt    = srb_pkg::fit_len(str_len_r);
          out_last_nxt   = last_byte;
          if (last_byte) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en        = 1'b1;
            str_addr_nxt = str_addr_r + MEM_AW'(1);
            str_pos_nxt  = str_pos_r + LEN_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    str_addr_r   <= str_addr_nxt;
    str_pos_r    <= str_pos_nxt;
    str_len_r    <= str_len_nxt;
    out_status_r <= out_status_nxt;
    out_byte_r   <= out_byte_nxt;
    out_len_r    <= out_len_nxt;
    out_last_r   <= out_last_nxt;
  end

  // slot control: valid bits, age pointer and the region map (a permutation)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      oldest_r     <= '0;
      spare_r      <= REGION_W'(srb_pkg::ENTRIES);
      for (int i = 0; i < srb_pkg::ENTRIES; i++) begin
        slot_map_r[i] <= REGION_W'(i);
      end
    end else if (tbl_clear) begin
      slot_valid_r <= '0;
      oldest_r     <= '0;
    end else if (tbl_commit) begin
      slot_valid_r[sel_slot] <= 1'b1;
      slot_map_r[sel_slot]   <= spare_r;
      spare_r                <= sel_region;
      if (!free_found) begin
        oldest_r <= (oldest_r == SLOT_W'(srb_pkg::ENTRIES - 1)) ? '0
                                                                : oldest_r + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_commit) begin
      slot_seq_r[sel_slot] <= head_cmd.seq;
      slot_len_r[sel_slot] <= head_cmd.len;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= head_cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_byte           = out_byte_r;
  assign out_payload_length = out_len_r;
  assign out_last_result    = out_last_r;

endmodule

@@ rtl/seqnum_resend_buffer.sv @@
// Top level of the sequence-number resend buffer.
//
// Resend buffer keyed by 16-bit sequence numbers, 8 slots of up to 32 bytes.
// Input channel (in_valid / in_stall): one word per cycle while in_stall is low. Opcode write carries
// one payload byte; the word with in_final_byte set commits the payload under
// in_seq_number into a free slot, or over the oldest slot when all are in use.
// Lookup streams the oldest matching payload, one result word per byte, or
// returns a single not-found word. Clear empties the table.
// Result channel (out_valid / out_stall): out_last_result marks the final word
// of each request. A commit result is registered as the engine takes the
// command from the queue; a lookup hit first reads the payload RAM into a
// register, then streams one byte per cycle while out_stall is low. The
// front end takes one word per cycle into a 4-deep command queue while it
// is not full; the engine retires writes and clears freely, a commit or miss
// once the result register is free, a hit byte by byte on one RAM port.
// Payload RAM has one spare region that collects the pending write, so a
// commit is a slot remap and no copy. A stalled receiver holds the result
// register; the engine waits and the queue fills, then in_stall rises.
// Reset (rst_n low, synchronous) empties the table and the queue and drops
// any partially written payload.
`timescale 1ns / 1ps
`include "seqnum_resend_buffer_assert.svh"
module seqnum_resend_buffer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [srb_pkg::OP_W-1:0]      in_opcode,
  input  logic [srb_pkg::SEQ_W-1:0]     in_seq_number,
  input  logic [srb_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic                          in_final_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [srb_pkg::ST_W-1:0]      out_status,
  output logic [srb_pkg::BYTE_W-1:0]    out_byte,
  output logic [srb_pkg::OUT_LEN_W-1:0] out_payload_length,
  output logic                          out_last_result
);

  // front end -> queue
  logic             q_push;
  srb_pkg::cmd_t    q_cmd;
  // queue -> table engine
  logic             q_pop;
  srb_pkg::cmd_t    head_cmd;
  srb_pkg::q_stat_t q_stat;

  srb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_seq_number (in_seq_number),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_cmd         (q_cmd)
  );

  srb_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  srb_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_cmd           (head_cmd),
    .q_stat             (q_stat),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_byte           (out_byte),
    .out_payload_length (out_payload_length),
    .out_last_result    (out_last_result)
  );

  // queue bookkeeping between the two halves
  `SRB_ASSERT_IMP(a_no_push_full, q_push, !q_stat.full, "command pushed into full queue")
  `SRB_ASSERT_IMP(a_no_pop_empty, q_pop, !q_stat.empty, "command popped from empty queue")
  `SRB_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_stat.empty, "queue empty after push")

endmodule

@@ tb/seqnum_resend_buffer_checker.sv @@
// Checker for the resend buffer: mirrors the slot table, queues expected result words, compares.
`timescale 1ns / 1ps
module seqnum_resend_buffer_checker
  import srb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic [SEQ_W-1:0]     in_seq_number,
  input  logic [BYTE_W-1:0]    in_data_byte,
  input  logic                 in_final_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [ST_W-1:0]      out_status,
  input  logic [BYTE_W-1:0]    out_byte,
  input  logic [OUT_LEN_W-1:0] out_payload_length,
  input  logic                 out_last_result,
  output int                   waiting,
  output int                   fail_count,
  output int                   checked,
  output int                   evicted,
  output int                   truncated
);

  typedef struct packed {
    status_t              status;
    logic [BYTE_W-1:0]    data;
    logic [OUT_LEN_W-1:0] len;
    logic                 last;
  } result_word_t;

  logic              table_valid [ENTRIES];
  logic [SEQ_W-1:0]  table_seq   [ENTRIES];
  int unsigned       table_len   [ENTRIES];
  logic [BYTE_W-1:0] table_bytes [ENTRIES][MAX_PAYLOAD];
  int unsigned       age_head;

  // payload being collected, survives lookups and clears
  logic [BYTE_W-1:0] open_bytes [MAX_PAYLOAD];
  int unsigned       open_count;
  logic              open_dropped;

  result_word_t due_results[$];
  int errors_i, checked_i, evicted_i, truncated_i;

  initial begin
    errors_i    = 0;
    checked_i   = 0;
    evicted_i   = 0;
    truncated_i = 0;
  end

  function automatic void queue_result(status_t st, logic [BYTE_W-1:0] data,
                                       int unsigned len, logic last);
    result_word_t w;
    w.status = st;
    w.data   = data;
    w.len    = OUT_LEN_W'(len);
    w.last   = last;
    due_results.push_back(w);
  endfunction

  function automatic void store_packet(logic [SEQ_W-1:0] key);
    int unsigned slot;
    int unsigned s;
    bit          free_found;
    slot       = age_head;
    free_found = 1'b0;
    for (int unsigned a = 0; a < ENTRIES; a++) begin
      s = (age_head + a) % ENTRIES;
      if (!free_found && !table_valid[s]) begin
        slot       = s;
        free_found = 1'b1;
      end
    end
    if (!free_found) begin
      age_head = (age_head + 1) % ENTRIES;
      evicted_i++;
    end
    table_valid[slot] = 1'b1;
    table_seq[slot]   = key;
    table_len[slot]   = open_count;
    for (int unsigned i = 0; i < open_count; i++)
      table_bytes[slot][i] = open_bytes[i];
    if (open_dropped)
      truncated_i++;
    queue_result(open_dropped ? ST_TRUNC : ST_STORED, '0, open_count, 1'b1);
    open_count   = 0;
    open_dropped = 1'b0;
  endfunction

  // oldest match wins
  function automatic void find_key(logic [SEQ_W-1:0] key);
    int unsigned s;
    for (int unsigned a = 0; a < ENTRIES; a++) begin
      s = (age_head + a) % ENTRIES;
      if (table_valid[s] && table_seq[s] == key) begin
        for (int unsigned i = 0; i < table_len[s]; i++)
          queue_result(ST_FOUND, table_bytes[s][i], table_len[s], i + 1 == table_len[s]);
        return;
      end
    end
    queue_result(ST_MISSING, '0, 0, 1'b1);
  endfunction

  function automatic void predict_word(logic [OP_W-1:0] op, logic [SEQ_W-1:0] key,
                                       logic [BYTE_W-1:0] data, logic fin);
    case (op)
      OP_WRITE: begin
        if (open_count < MAX_PAYLOAD) begin
          open_bytes[open_count] = data;
          open_count++;
        end else begin
          open_dropped = 1'b1;
        end
        if (fin)
          store_packet(key);
      end
      OP_LOOKUP: find_key(key);
      OP_CLEAR: begin
        for (int unsigned s = 0; s < ENTRIES; s++)
          table_valid[s] = 1'b0;
        age_head = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_result();
    result_word_t w;
    if (due_results.size() == 0) begin
      errors_i++;
      $error("unexpected result word: status %0d byte %0d length %0d last %0d",
             out_status, out_byte, out_payload_length, out_last_result);
      return;
    end
    w = due_results.pop_front();
    checked_i++;
    if (out_status !== w.status) begin
      errors_i++;
      $error("status: expected %0d, got %0d", w.status, out_status);
    end
    if (out_byte !== w.data) begin
      errors_i++;
      $error("out_byte: expected %0d, got %0d", w.data, out_byte);
    end
    if (out_payload_length !== w.len) begin
      errors_i++;
      $error("payload_length: expected %0d, got %0d", w.len, out_payload_length);
    end
    if (out_last_result !== w.last) begin
      errors_i++;
      $error("last_result: expected %0d, got %0d", w.last, out_last_result);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int unsigned s = 0; s < ENTRIES; s++)
        table_valid[s] = 1'b0;
      age_head     = 0;
      open_count   = 0;
      open_dropped = 1'b0;
      due_results.delete();
    end else begin
      if (in_valid === 1'b1 && in_stall === 1'b0)
        predict_word(in_opcode, in_seq_number, in_data_byte, in_final_byte);
      if (out_valid === 1'b1 && out_stall === 1'b0)
        check_result();
    end
    waiting    <= due_results.size();
    fail_count <= errors_i;
    checked    <= checked_i;
    evicted    <= evicted_i;
    truncated  <= truncated_i;
  end

endmodule

@@ tb/tb_seqnum_resend_buffer.sv @@
// Testbench top for the resend buffer: clock, reset, word stimulus, back pressure, verdict.
`timescale 1ns / 1ps
module tb_seqnum_resend_buffer;
  import srb_pkg::*;

  // opcode the block must ignore
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_WORDS  = 156;
  localparam int QUIET_LIMIT   = 2000;  // cycles with no word moving on either channel
  localparam int SETTLE_CYCLES = 16;    // catch stray result words after the last one due
  localparam int KEY_POOL_SIZE = 12;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [OP_W-1:0]      in_opcode;
  logic [SEQ_W-1:0]     in_seq_number;
  logic [BYTE_W-1:0]    in_data_byte;
  logic                 in_final_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [ST_W-1:0]      out_status;
  logic [BYTE_W-1:0]    out_byte;
  logic [OUT_LEN_W-1:0] out_payload_length;
  logic                 out_last_result;

  int waiting, fail_count, checked, evicted, truncated;

  // word counts for the summary
  int n_write, n_lookup, n_clear, n_ignored, words_taken;
  int quiet_cycles;
  logic calm;  // no idling on either side
  logic [SEQ_W-1:0] key_pool[$];

  seqnum_resend_buffer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_seq_number      (in_seq_number),
    .in_data_byte       (in_data_byte),
    .in_final_byte      (in_final_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_byte           (out_byte),
    .out_payload_length (out_payload_length),
    .out_last_result    (out_last_result)
  );

  seqnum_resend_buffer_checker u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_seq_number      (in_seq_number),
    .in_data_byte       (in_data_byte),
    .in_final_byte      (in_final_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_byte           (out_byte),
    .out_payload_length (out_payload_length),
    .out_last_result    (out_last_result),
    .waiting            (waiting),
    .fail_count         (fail_count),
    .checked            (checked),
    .evicted            (evicted),
    .truncated          (truncated)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Watchdog: a correct run never goes this long without moving a word.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d result words still due",
               QUIET_LIMIT, waiting);
      $display("tb_seqnum_resend_buffer: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver back pressure: free runs broken by stall bursts.
  // Long free runs now and then give stretches with no stall at all.
  initial begin
    out_stall <= 1'b0;
    forever begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(30, 80)) @(posedge clk);
      else
        repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!calm) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  // Offer one word and hold it until taken. Called at a rising edge; returns at
  // the edge that took the word. The sender sometimes idles first.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [SEQ_W-1:0] key,
                           input logic [BYTE_W-1:0] data, input logic fin);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_seq_number <= key;
    in_data_byte  <= data;
    in_final_byte <= fin;
    do @(posedge clk); while (in_stall !== 1'b0);
    case (op)
      OP_WRITE:  n_write++;
      OP_LOOKUP: n_lookup++;
      OP_CLEAR:  n_clear++;
      default:   n_ignored++;
    endcase
    if (op != OP_UNUSED)
      words_taken++;
  endtask

  // A whole packet: nbytes write words, the last one commits under key.
  // Sequence numbers on the earlier bytes are don't-care, so they get noise.
  task automatic send_packet(input logic [SEQ_W-1:0] key, input int unsigned nbytes);
    for (int unsigned i = 1; i <= nbytes; i++)
      send_word(OP_WRITE, (i == nbytes) ? key : SEQ_W'($urandom),
                BYTE_W'($urandom), i == nbytes);
    key_pool.push_back(key);
    if (key_pool.size() > KEY_POOL_SIZE)
      void'(key_pool.pop_front());
  endtask

  // Mostly keys that were stored recently, so lookups hit.
  function automatic logic [SEQ_W-1:0] pick_key();
    if (key_pool.size() != 0 && $urandom_range(0, 3) != 0)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    return SEQ_W'($urandom);
  endfunction

  // Hold off the sender until every result word due has come back.
  // The first edge lets the checker count the word just taken.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned start;
    int unsigned pick;
    bit          pressed;

    n_write       = 0;
    n_lookup      = 0;
    n_clear       = 0;
    n_ignored     = 0;
    words_taken   = 0;
    calm          = 1'b0;
    pressed       = 1'b0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_opcode     <= OP_WRITE;
    in_seq_number <= '0;
    in_data_byte  <= '0;
    in_final_byte <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // empty table: miss; unused opcode and clear do nothing
    send_word(OP_LOOKUP, 16'h0000, 8'h00, 1'b0);
    send_word(OP_UNUSED, 16'hFFFF, 8'hFF, 1'b1);
    send_word(OP_CLEAR, 16'h0000, 8'h00, 1'b0);
    // two-byte packet, then single-byte packets until the table is full
    // and the ninth one evicts the first
    send_word(OP_WRITE, 16'h0000, 8'hA5, 1'b0);
    send_word(OP_WRITE, 16'hFFFF, 8'h5A, 1'b1);
    send_word(OP_WRITE, 16'h0000, 8'h00, 1'b1);
    send_word(OP_WRITE, 16'h1234, 8'hFF, 1'b1);
    send_word(OP_WRITE, 16'h1234, 8'h3C, 1'b1);  // duplicate key, newer
    send_word(OP_WRITE, 16'h8000, 8'h80, 1'b1);
    send_word(OP_WRITE, 16'h0001, 8'h01, 1'b1);
    send_word(OP_WRITE, 16'h7FFF, 8'h7F, 1'b1);
    send_word(OP_WRITE, 16'hAAAA, 8'hAA, 1'b1);
    send_word(OP_WRITE, 16'h5555, 8'h55, 1'b1);
    // oldest duplicate returned; evicted key misses; newest hits
    send_word(OP_LOOKUP, 16'h1234, 8'h00, 1'b1);
    send_word(OP_LOOKUP, 16'hFFFF, 8'h00, 1'b0);
    send_word(OP_LOOKUP, 16'h5555, 8'hFF, 1'b1);
    // lookup and clear in the middle of a write keep the pending byte
    send_word(OP_WRITE, 16'h0000, 8'h11, 1'b0);
    send_word(OP_LOOKUP, 16'h0000, 8'h00, 1'b0);
    send_word(OP_CLEAR, 16'hFFFF, 8'hFF, 1'b1);
    send_word(OP_WRITE, 16'hBEEF, 8'h22, 1'b1);
    send_word(OP_LOOKUP, 16'hBEEF, 8'h00, 1'b0);
    drain();

    // --- random part ---
    // Mostly well-formed packets with lookups on recent keys; some clears,
    // ignored opcodes and stray write bytes that glue onto the next packet.
    start = words_taken;
    send_packet(SEQ_W'($urandom), MAX_PAYLOAD + 2);  // overlong: truncated store
    while (words_taken - start < RANDOM_WORDS) begin
      if (!pressed && words_taken - start >= RANDOM_WORDS / 2) begin
        drain();
        pressed = 1'b1;
      end
      if (words_taken - start >= RANDOM_WORDS * 3 / 4)
        calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 55)
        send_packet(pick_key(), ($urandom_range(0, 7) == 0)
                    ? $urandom_range(MAX_PAYLOAD - 2, MAX_PAYLOAD + 4)
                    : $urandom_range(1, 6));
      else if (pick < 85)
        send_word(OP_LOOKUP, pick_key(), BYTE_W'($urandom), 1'($urandom));
      else if (pick < 90)
        send_word(OP_CLEAR, SEQ_W'($urandom), BYTE_W'($urandom), 1'($urandom));
      else if (pick < 94)
        send_word(OP_UNUSED, SEQ_W'($urandom), BYTE_W'($urandom), 1'($urandom));
      else
        send_word(OP_WRITE, SEQ_W'($urandom), BYTE_W'($urandom), 1'b0);
    end

    // --- wind down ---
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d write bytes, %0d lookups, %0d clears, %0d ignored words",
             n_write, n_lookup, n_clear, n_ignored);
    $display("%0d result words checked, %0d evictions, %0d truncated stores",
             checked, evicted, truncated);
    if (fail_count == 0 && waiting == 0)
      $display("tb_seqnum_resend_buffer: clean");
    else
      $display("tb_seqnum_resend_buffer: errors");
    $finish;
  end

endmodule
